// ===== design/acbc_pkg.sv =====
// Shared types, constants and byte- and word-level functions for the AES-CBC cipher.
`default_nettype none
package acbc_pkg;

    typedef enum logic [2:0] {
        REG_KEY_0        = 3'd0,
        REG_KEY_1        = 3'd1,
        REG_KEY_2        = 3'd2,
        REG_KEY_3        = 3'd3,
        REG_IV_HI        = 3'd4,
        REG_IV_LO        = 3'd5,
        REG_KEY_SIZE     = 3'd6,
        REG_DECRYPT_MODE = 3'd7
    } reg_index_t;

    localparam int unsigned CfgIndexWidth = 3;
    localparam logic [7:0]  RconFirst     = 8'h01;
    localparam logic [7:0]  ReducePoly    = 8'h1b;

    // key schedule status handed from the expander to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } kx_status_t;

    function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[b];
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] b);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? ReducePoly : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
    endfunction

    // column mix, forward and inverse; inverse uses the 0e/0b/0d/09 matrix
    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] r [4];
        for (int k = 0; k < 4; k++) begin
            a[k]  = c[31 - 8 * k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ a[k];
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        for (int q = 0; q < 4; q++) begin
            if (inv)
                r[q] = me[q] ^ mb[(q + 1) % 4] ^ md[(q + 2) % 4] ^ m9[(q + 3) % 4];
            else
                r[q] = m2[q] ^ m3[(q + 1) % 4] ^ a[(q + 2) % 4] ^ a[(q + 3) % 4];
        end
        return {r[0], r[1], r[2], r[3]};
    endfunction

endpackage
`default_nettype wire

// ===== design/acbc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module acbc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 60
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== design/acbc_key_expand.sv =====
// Key schedule sequencer: writes one round key word per cycle into the key RAM.
`default_nettype none
module acbc_key_expand #(
    parameter int unsigned DEPTH = 60
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     use_256,
    input  wire logic [255:0]             key,
    output logic                          wr_en,
    output logic      [$clog2(DEPTH)-1:0] wr_addr,
    output logic      [31:0]              wr_data,
    output acbc_pkg::kx_status_t          status
);

    localparam int unsigned AW = $clog2(DEPTH);

    typedef enum logic [1:0] { KX_IDLE, KX_RUN, KX_DONE } kx_state_t;

    kx_state_t       state_reg;
    logic [5:0]      idx_reg;
    logic [7:0]      rcon_reg;
    // sliding window of the last nk words, newest at [0]
    logic [31:0]     win_reg [8];
    logic [5:0]      total;
    logic [31:0]     prev;
    logic [31:0]     back;
    logic [31:0]     t;
    logic [31:0]     w_new;
    logic [2:0]      phase;
    logic            in_key;

    assign total  = use_256 ? 6'd60 : 6'd44;
    assign phase  = idx_reg[2:0];
    assign in_key = use_256 ? (idx_reg < 6'd8) : (idx_reg < 6'd4);
    assign prev   = win_reg[0];
    assign back   = use_256 ? win_reg[7] : win_reg[3];

    always_comb
    begin
        t = prev;
        if ((use_256 && phase == 3'd0) || (!use_256 && phase[1:0] == 2'd0))
            t = acbc_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'h0};
        else if (use_256 && phase == 3'd4)
            t = acbc_pkg::sub_word(prev);
        if (in_key)
            w_new = key[255 - 32 * idx_reg[2:0] -: 32];
        else
            w_new = back ^ t;
    end

    assign wr_en   = (state_reg == KX_RUN) && (32'(idx_reg) < DEPTH);
    assign wr_addr = AW'(idx_reg);
    assign wr_data = w_new;
    assign status.busy = (state_reg == KX_RUN);
    assign status.done = (state_reg == KX_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KX_IDLE;
            idx_reg   <= '0;
            rcon_reg  <= acbc_pkg::RconFirst;
        end
        else
        begin
            unique case (state_reg)
                KX_IDLE, KX_DONE:
                begin
                    if (start)
                    begin
                        state_reg <= KX_RUN;
                        idx_reg   <= '0;
                        rcon_reg  <= acbc_pkg::RconFirst;
                    end
                end
                KX_RUN:
                begin
                    idx_reg <= idx_reg + 6'd1;
                    if (!in_key && ((use_256 && phase == 3'd0) ||
                                    (!use_256 && phase[1:0] == 2'd0)))
                        rcon_reg <= acbc_pkg::xtime(rcon_reg);
                    if (idx_reg == total - 6'd1)
                        state_reg <= KX_DONE;
                end
                default: state_reg <= KX_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == KX_RUN)
        begin
            win_reg[0] <= w_new;
            for (int k = 1; k < 8; k++)
                win_reg[k] <= win_reg[k - 1];
        end
    end

`ifndef SYNTHESIS
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == KX_RUN && idx_reg == total - 6'd1 && !start) |=> status.done)
        else $error("key schedule did not finish");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.busy && status.done))
        else $error("key schedule busy and done together");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> idx_reg < total)
        else $error("key schedule index overran");
`endif

endmodule
`default_nettype wire

// ===== design/acbc_round.sv =====
// Round sequencer: each AES round runs after its four key words are read from the key RAM.
`default_nettype none
module acbc_round #(
    parameter int unsigned DEPTH = 60
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     decrypt,
    input  wire logic                     use_256,
    input  wire logic [127:0]             block_in,
    output logic      [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic [31:0]              rd_data,
    output logic                          busy,
    output logic                          done,
    output logic      [127:0]             block_out
);

    localparam int unsigned AW = $clog2(DEPTH);

    typedef enum logic [1:0] { RD_IDLE, RD_FETCH, RD_ROUND } rd_state_t;

    rd_state_t     state_reg;
    logic [3:0]    round_reg;   // round whose key is being gathered
    logic [1:0]    word_reg;
    logic [3:0]    nr;
    logic [127:0]  state_blk_reg;
    logic [95:0]   kacc_reg;
    logic          first_reg;
    logic          fetch_pend_reg;
    logic [127:0]  rkey;
    logic [127:0]  sb;
    logic [127:0]  mixed;
    logic [127:0]  step;
    logic          is_final;
    logic [5:0]    addr_full;

    assign nr = use_256 ? 4'd14 : 4'd10;
    assign rkey = {kacc_reg, rd_data};
    assign addr_full = {round_reg, 2'b00} + {4'd0, word_reg};
    assign rd_addr = AW'(addr_full);
    // encrypt counts rounds up, decrypt down; round_reg holds the key round
    assign is_final = (round_reg == (decrypt ? 4'd0 : nr));

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                    sb[127 - 8 * (4 * c + r) -: 8] = acbc_pkg::sbox_inv(
                        state_blk_reg[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8]);
                else
                    sb[127 - 8 * (4 * c + r) -: 8] = acbc_pkg::sbox_fwd(
                        state_blk_reg[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
            end
        if (decrypt)
        begin
            // inverse: sub/shift, add key, then inverse mix unless final
            for (int c = 0; c < 4; c++)
                mixed[127 - 32 * c -: 32] = acbc_pkg::mix_col(
                    sb[127 - 32 * c -: 32] ^ rkey[127 - 32 * c -: 32], 1'b1);
            step = is_final ? (sb ^ rkey) : mixed;
        end
        else
        begin
            for (int c = 0; c < 4; c++)
                mixed[127 - 32 * c -: 32] = acbc_pkg::mix_col(sb[127 - 32 * c -: 32], 1'b0);
            step = (is_final ? sb : mixed) ^ rkey;
        end
        if (first_reg)
            step = state_blk_reg ^ rkey;
    end

    assign busy      = (state_reg != RD_IDLE);
    assign block_out = state_blk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= RD_IDLE;
            round_reg      <= '0;
            word_reg       <= '0;
            first_reg      <= 1'b0;
            fetch_pend_reg <= 1'b0;
            done           <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                RD_IDLE:
                begin
                    if (start)
                    begin
                        state_reg      <= RD_FETCH;
                        round_reg      <= decrypt ? nr : 4'd0;
                        word_reg       <= '0;
                        first_reg      <= 1'b1;
                        fetch_pend_reg <= 1'b0;
                    end
                end
                RD_FETCH:
                begin
                    // addresses word 0..3 of the key; the data comes from the registered RAM read port
                    fetch_pend_reg <= 1'b1;
                    if (word_reg == 2'd3)
                        state_reg <= RD_ROUND;
                    else
                        word_reg <= word_reg + 2'd1;
                end
                RD_ROUND:
                begin
                    first_reg <= 1'b0;
                    word_reg  <= '0;
                    fetch_pend_reg <= 1'b0;
                    if (is_final && !first_reg)
                    begin
                        state_reg <= RD_IDLE;
                        done      <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= RD_FETCH;
                        round_reg <= decrypt ? round_reg - 4'd1 : round_reg + 4'd1;
                    end
                end
                default: state_reg <= RD_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == RD_IDLE && start)
            state_blk_reg <= block_in;
        else if (state_reg == RD_ROUND)
            state_blk_reg <= step;
        if (state_reg == RD_FETCH && fetch_pend_reg)
            kacc_reg <= {kacc_reg[63:0], rd_data};
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> round_reg <= nr)
        else $error("round index out of range");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("round done held");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == RD_IDLE)
        else $error("done while busy");
`endif

endmodule
`default_nettype wire

// ===== design/aes_cbc_block_cipher.sv =====
// Top level: AES-128/256 CBC encrypt and decrypt with config registers.
// AES-128/256 in CBC mode. One 128-bit item is processed at a time. After a
// key or key-length write, the first item first waits for the round key
// schedule, which writes one key word per cycle into the round key RAM and
// then hands over to the round sequencer. Each item then runs 11 (128-bit)
// or 15 (256-bit) rounds, each made of four key word reads from the
// single-read-port key RAM followed by the round itself. When the rounds
// finish, the result and the next chaining value are registered together.
// The next item is accepted once its predecessor's result sits in the output
// register and out_stall is not holding it there.
`default_nettype none
module aes_cbc_block_cipher #(
    parameter int unsigned ROUND_KEY_DEPTH = 60
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [acbc_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] data_hi,
    input  wire logic [63:0] data_lo,
    input  wire logic        last_block,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [63:0] result_hi,
    output logic      [63:0] result_lo
);

    localparam int unsigned AW = $clog2(ROUND_KEY_DEPTH);

    typedef enum logic [1:0] { TOP_IDLE, TOP_EXPAND, TOP_CIPHER } top_state_t;

    top_state_t   state_reg;
    logic [255:0] key_reg;
    logic [127:0] iv_reg;
    logic [127:0] chain_reg;
    logic [127:0] in_blk_reg;
    logic         last_reg;
    logic         wide_key_reg;
    logic         decrypt_reg;
    logic         expanded_reg;
    logic         cfg_we;
    logic         in_acc;
    logic         use_256;

    logic         kx_start;
    logic         kx_wr_en;
    logic [AW-1:0] kx_wr_addr;
    logic [31:0]  kx_wr_data;
    acbc_pkg::kx_status_t kx_status;

    logic         rd_start;
    logic [AW-1:0] rd_addr;
    logic [31:0]  rd_data;
    logic         rd_busy;
    logic         rd_done;
    logic [127:0] rd_out;
    logic [127:0] blk_src;
    logic [127:0] cipher_in;
    logic [127:0] res;

    assign use_256   = wide_key_reg && (ROUND_KEY_DEPTH >= 60);
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != TOP_IDLE) || (out_valid && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign kx_start  = (state_reg == TOP_IDLE) && in_acc && !expanded_reg;
    assign rd_start  = ((state_reg == TOP_IDLE) && in_acc && expanded_reg) ||
                       ((state_reg == TOP_EXPAND) && kx_status.done);
    // with keys ready the rounds start on the accepting edge, from the port
    assign blk_src   = (state_reg == TOP_IDLE) ? {data_hi, data_lo} : in_blk_reg;
    assign cipher_in = decrypt_reg ? blk_src : (blk_src ^ chain_reg);
    assign res       = decrypt_reg ? (rd_out ^ chain_reg) : rd_out;

    acbc_ram #(.WIDTH(32), .DEPTH(ROUND_KEY_DEPTH)) u_key_ram (
        .clk     (clk),
        .wr_en   (kx_wr_en),
        .wr_addr (kx_wr_addr),
        .wr_data (kx_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    acbc_key_expand #(.DEPTH(ROUND_KEY_DEPTH)) u_kx (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (kx_start),
        .use_256 (use_256),
        .key     (key_reg),
        .wr_en   (kx_wr_en),
        .wr_addr (kx_wr_addr),
        .wr_data (kx_wr_data),
        .status  (kx_status)
    );

    acbc_round #(.DEPTH(ROUND_KEY_DEPTH)) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rd_start),
        .decrypt   (decrypt_reg),
        .use_256   (use_256),
        .block_in  (cipher_in),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (rd_busy),
        .done      (rd_done),
        .block_out (rd_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= TOP_IDLE;
            key_reg      <= '0;
            iv_reg       <= '0;
            chain_reg    <= '0;
            wide_key_reg <= 1'b0;
            decrypt_reg  <= 1'b0;
            expanded_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            if (cfg_we)
            begin
                unique case (acbc_pkg::reg_index_t'(cfg_index))
                    acbc_pkg::REG_KEY_0:
                    begin
                        key_reg[255:192] <= cfg_data;
                        expanded_reg     <= 1'b0;
                    end
                    acbc_pkg::REG_KEY_1:
                    begin
                        key_reg[191:128] <= cfg_data;
                        expanded_reg     <= 1'b0;
                    end
                    acbc_pkg::REG_KEY_2:
                    begin
                        key_reg[127:64] <= cfg_data;
                        expanded_reg    <= 1'b0;
                    end
                    acbc_pkg::REG_KEY_3:
                    begin
                        key_reg[63:0] <= cfg_data;
                        expanded_reg  <= 1'b0;
                    end
                    acbc_pkg::REG_IV_HI:
                    begin
                        iv_reg[127:64]    <= cfg_data;
                        chain_reg         <= {cfg_data, iv_reg[63:0]};
                    end
                    acbc_pkg::REG_IV_LO:
                    begin
                        iv_reg[63:0]      <= cfg_data;
                        chain_reg         <= {iv_reg[127:64], cfg_data};
                    end
                    acbc_pkg::REG_KEY_SIZE:
                    begin
                        wide_key_reg <= cfg_data[0];
                        expanded_reg <= 1'b0;
                    end
                    acbc_pkg::REG_DECRYPT_MODE: decrypt_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                TOP_IDLE:
                begin
                    if (in_acc)
                        state_reg <= expanded_reg ? TOP_CIPHER : TOP_EXPAND;
                end
                TOP_EXPAND:
                begin
                    if (kx_status.done)
                    begin
                        expanded_reg <= 1'b1;
                        state_reg    <= TOP_CIPHER;
                    end
                end
                TOP_CIPHER:
                begin
                    if (rd_done)
                    begin
                        out_valid <= 1'b1;
                        state_reg <= TOP_IDLE;
                        if (last_reg)
                            chain_reg <= iv_reg;
                        else
                            chain_reg <= decrypt_reg ? in_blk_reg : rd_out;
                    end
                end
                default: state_reg <= TOP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_blk_reg <= {data_hi, data_lo};
            last_reg   <= last_block;
        end
        if (state_reg == TOP_CIPHER && rd_done)
        begin
            result_hi <= res[127:64];
            result_lo <= res[63:0];
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_busy || kx_status.busy) |-> in_stall)
        else $error("item accepted while busy");
    a_cipher_after_expand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TOP_EXPAND && kx_status.done) |=> rd_busy)
        else $error("cipher did not start after key schedule");
    a_done_in_cipher: assert property (@(posedge clk) disable iff (!rst_n)
        rd_done |-> state_reg == TOP_CIPHER)
        else $error("round done outside cipher state");
`endif

endmodule
`default_nettype wire
